// File: hw/rtl/c3zp_pkg.sv
package c3zp_pkg;

    // fixed field widths of the pixel stream and the result
    localparam int PIX_W  = 16;
    localparam int COEF_W = 16;
    localparam int PROD_W = PIX_W + COEF_W;
    localparam int PART_W = PROD_W + 2;
    localparam int SUM_W  = 35;
    localparam int ROW_W  = 12;

    // default line store depth
    localparam int DEF_MAX_WIDTH = 2048;

    typedef logic signed [PIX_W-1:0]  pix_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    // one window column, element 0 is the top row
    typedef pix_t  [2:0] col_t;
    typedef coef_t [2:0] coef_col_t;

    // control shared by the column cells; the right cell sees clear held low
    typedef struct packed {
        logic shift;
        logic clear;
        logic issue;
        logic vshift;
        logic hshift;
        logic sum_en;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/c3zp_col_cell.sv
module c3zp_col_cell
    import c3zp_pkg::*;
(
    input  logic                     aclk,
    input  cell_ctrl_t               ctrl,
    input  col_t                     shift_in,
    input  col_t                     right_col,
    input  coef_col_t                coef_col,
    output col_t                     col_out,
    output logic signed [PART_W-1:0] part_out
);

    col_t                     col_reg;
    col_t                     src;
    col_t                     taps;
    logic signed [PROD_W-1:0] prod_reg  [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [PART_W-1:0] part_reg;
    logic signed [PART_W-1:0] part_next;

    // window column, takes the neighbour's column on every beat into the window
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            col_reg <= ctrl.clear ? '0 : shift_in;
        end
    end

    // tap selection: right neighbour for a missing column, rows moved up for a missing row
    always_comb begin
        src = ctrl.hshift ? right_col : col_reg;
        if (ctrl.vshift) begin
            taps[0] = src[1];
            taps[1] = src[2];
            taps[2] = '0;
        end else begin
            taps = src;
        end
    end

    // three products of this kernel column
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod_next[k] = $signed(taps[k]) * $signed(coef_col[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.issue) begin
            prod_reg <= prod_next;
        end
    end

    // column partial sum
    assign part_next = PART_W'(prod_reg[0]) + PART_W'(prod_reg[1]) + PART_W'(prod_reg[2]);

    always_ff @(posedge aclk) begin
        if (ctrl.sum_en) begin
            part_reg <= part_next;
        end
    end

    assign col_out  = col_reg;
    assign part_out = part_reg;

endmodule

// File: hw/rtl/c3zp_line_store.sv
module c3zp_line_store
    import c3zp_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_WIDTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              bank,
    input  logic [ADDR_W-1:0] addr,
    input  logic [PIX_W-1:0]  wdata,
    output logic [PIX_W-1:0]  rd_even,
    output logic [PIX_W-1:0]  rd_odd
);

    logic [PIX_W-1:0] even_mem [DEPTH];
    logic [PIX_W-1:0] odd_mem  [DEPTH];
    logic [PIX_W-1:0] rd_even_reg;
    logic [PIX_W-1:0] rd_odd_reg;

    // even rows, read before write at the same column
    always_ff @(posedge aclk) begin
        if (en) begin
            rd_even_reg <= even_mem[addr];
            if (!bank) begin
                even_mem[addr] <= wdata;
            end
        end
    end

    // odd rows
    always_ff @(posedge aclk) begin
        if (en) begin
            rd_odd_reg <= odd_mem[addr];
            if (bank) begin
                odd_mem[addr] <= wdata;
            end
        end
    end

    assign rd_even = rd_even_reg;
    assign rd_odd  = rd_odd_reg;

endmodule

// File: hw/rtl/conv3x3_zero_padded_stream_core.sv
// 3x3 convolution of a raster pixel stream with zero padding at the image edges. One pixel
// beat is taken per clock unless stalled. Each beat gives zero to four result beats: one in
// the body of the image, two in the last column, two in the last row and four at the
// bottom-right pixel; the result port carries at most one beat per clock, so in the last
// column and row the input is held off while extra results drain. An accepted pixel passes
// the line store read, window column cell, product, column sum and final sum registers.
// The two line stores of MAX_WIDTH pixels are chosen by row parity and need no clearing
// pass: row 0 uses neither read and row 1 only the row above it. Writing the height or the
// width restarts the frame at row 0, column 0; configure only while no beat is in flight.
module conv3x3_zero_padded_stream_core
    import c3zp_pkg::*;
#(
    parameter  int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // pixel stream
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [PIX_W-1:0] s_pixel,
    // result stream
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SUM_W-1:0] m_filtered,
    output logic [ROW_W-1:0]        m_out_row,
    output logic [COL_W-1:0]        m_out_col,
    output logic                    m_run_last,
    output logic                    m_frame_done,
    // register port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [5:0]              paddr,
    input  logic [63:0]             pwdata,
    output logic [63:0]             prdata,
    output logic                    pready
);

    localparam int CFG_W      = 64;
    localparam int COEF_ROW_W = 3 * COEF_W;
    localparam int ROWS_CFG_W = 13;
    localparam int COLS_CFG_W = 12;
    localparam int MAX_HEIGHT = 4096;
    localparam int CEXT_W     = (COL_W + 1 > COLS_CFG_W) ? COL_W + 1 : COLS_CFG_W;

    localparam logic [2:0] REG_COEFF_TOP = 3'd0;
    localparam logic [2:0] REG_COEFF_MID = 3'd1;
    localparam logic [2:0] REG_COEFF_BOT = 3'd2;
    localparam logic [2:0] REG_ROWS      = 3'd3;
    localparam logic [2:0] REG_COLS      = 3'd4;

    localparam logic [COEF_ROW_W-1:0] COEFF_MID_RESET = COEF_ROW_W'(1 << (COEF_W + 12));
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET      = ROWS_CFG_W'(1024);
    localparam logic [COLS_CFG_W-1:0] COLS_RESET      = COLS_CFG_W'(1024);

    // result kinds of one pixel, as bit positions of the job mask
    localparam logic [1:0] JOB_INNER  = 2'd0;
    localparam logic [1:0] JOB_RIGHT  = 2'd1;
    localparam logic [1:0] JOB_BELOW  = 2'd2;
    localparam logic [1:0] JOB_CORNER = 2'd3;

    // configuration
    logic [COEF_ROW_W-1:0] coef_top_reg;
    logic [COEF_ROW_W-1:0] coef_mid_reg;
    logic [COEF_ROW_W-1:0] coef_bot_reg;
    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [COLS_CFG_W-1:0] cols_reg;
    logic [2:0]            cfg_idx;
    logic                  cfg_wr;
    logic [ROW_W-1:0]      last_row;
    logic [COL_W-1:0]      last_col;
    logic [CEXT_W-1:0]     cols_ext;

    // positions
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             accept;
    logic [3:0]       mask_next;

    // read stage
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_clear_reg;
    logic [3:0]       s1_mask_reg;
    logic             s1_ge1_reg;
    logic             s1_ge2_reg;
    logic             s1_bank_reg;
    logic [PIX_W-1:0] rd_even;
    logic [PIX_W-1:0] rd_odd;
    col_t             new_col;

    // window stage
    logic [3:0]       w_mask_reg;
    logic [ROW_W-1:0] w_row_reg;
    logic [COL_W-1:0] w_col_reg;
    logic [1:0]       job;
    logic             w_busy;
    logic             w_last;

    // product, column sum and output stages
    logic             p_valid_reg;
    logic [ROW_W-1:0] p_row_reg;
    logic [COL_W-1:0] p_col_reg;
    logic             p_last_reg;
    logic             p_done_reg;
    logic             q_valid_reg;
    logic [ROW_W-1:0] q_row_reg;
    logic [COL_W-1:0] q_col_reg;
    logic             q_last_reg;
    logic             q_done_reg;
    logic             m_valid_reg;
    logic [SUM_W-1:0] filt_reg;
    logic [ROW_W-1:0] o_row_reg;
    logic [COL_W-1:0] o_col_reg;
    logic             o_last_reg;
    logic             o_done_reg;

    // flow
    logic o_ld;
    logic q_ld;
    logic p_ld;
    logic w_free;
    logic s1_ld_w;

    // cells
    cell_ctrl_t               ctrl;
    cell_ctrl_t               ctrl_right;
    col_t                     cell_col [3];
    coef_col_t                coef_col [3];
    logic signed [PART_W-1:0] part [3];
    logic signed [PART_W+1:0] total;

    // register port
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_top_reg <= '0;
            coef_mid_reg <= COEFF_MID_RESET;
            coef_bot_reg <= '0;
            rows_reg     <= ROWS_RESET;
            cols_reg     <= COLS_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_COEFF_TOP: coef_top_reg <= pwdata[COEF_ROW_W-1:0];
                REG_COEFF_MID: coef_mid_reg <= pwdata[COEF_ROW_W-1:0];
                REG_COEFF_BOT: coef_bot_reg <= pwdata[COEF_ROW_W-1:0];
                REG_ROWS:      rows_reg     <= pwdata[ROWS_CFG_W-1:0];
                REG_COLS:      cols_reg     <= pwdata[COLS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_COEFF_TOP: prdata = CFG_W'(coef_top_reg);
            REG_COEFF_MID: prdata = CFG_W'(coef_mid_reg);
            REG_COEFF_BOT: prdata = CFG_W'(coef_bot_reg);
            REG_ROWS:      prdata = CFG_W'(rows_reg);
            REG_COLS:      prdata = CFG_W'(cols_reg);
            default:       prdata = '0;
        endcase
    end

    // image size, zero acts as one, large values saturate
    always_comb begin
        if (rows_reg == '0) begin
            last_row = '0;
        end else if (rows_reg >= ROWS_CFG_W'(MAX_HEIGHT)) begin
            last_row = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            last_row = ROW_W'(rows_reg - 1'b1);
        end
    end

    assign cols_ext = CEXT_W'(cols_reg);

    always_comb begin
        if (cols_reg == '0) begin
            last_col = '0;
        end else if (cols_ext >= CEXT_W'(MAX_WIDTH)) begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            last_col = COL_W'(cols_ext - 1'b1);
        end
    end

    // pipeline flow, each stage loads when the next one is free or moving on
    assign o_ld    = q_valid_reg && (!m_valid_reg || m_ready);
    assign q_ld    = p_valid_reg && (!q_valid_reg || o_ld);
    assign p_ld    = w_busy && (!p_valid_reg || q_ld);
    assign w_free  = !w_busy || (p_ld && w_last);
    assign s1_ld_w = s1_valid_reg && w_free;
    assign s_ready = !s1_valid_reg || s1_ld_w;
    assign accept  = s_valid && s_ready;

    // raster position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (cfg_wr && (cfg_idx == REG_ROWS || cfg_idx == REG_COLS)) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            if (col_reg == last_col) begin
                col_reg <= '0;
                row_reg <= (row_reg == last_row) ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // results this pixel releases
    always_comb begin
        mask_next[JOB_INNER]  = (row_reg != '0) && (col_reg != '0);
        mask_next[JOB_RIGHT]  = (row_reg != '0) && (col_reg == last_col);
        mask_next[JOB_BELOW]  = (row_reg == last_row) && (col_reg != '0);
        mask_next[JOB_CORNER] = (row_reg == last_row) && (col_reg == last_col);
    end

    // line stores, the bank of a row's parity holds the row two above
    c3zp_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .aclk    (aclk),
        .en      (accept),
        .bank    (row_reg[0]),
        .addr    (col_reg),
        .wdata   (s_pixel),
        .rd_even (rd_even),
        .rd_odd  (rd_odd)
    );

    // read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_ld_w) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg   <= s_pixel;
            s1_row_reg   <= row_reg;
            s1_col_reg   <= col_reg;
            s1_clear_reg <= (col_reg == '0);
            s1_mask_reg  <= mask_next;
            s1_ge1_reg   <= (row_reg != '0);
            s1_ge2_reg   <= (row_reg > ROW_W'(1));
            s1_bank_reg  <= row_reg[0];
        end
    end

    // incoming column, rows above the frame read as zero
    always_comb begin
        new_col[2] = s1_pix_reg;
        new_col[1] = s1_ge1_reg ? (s1_bank_reg ? rd_even : rd_odd) : '0;
        new_col[0] = s1_ge2_reg ? (s1_bank_reg ? rd_odd : rd_even) : '0;
    end

    // job selection, lowest pending result first
    always_comb begin
        if (w_mask_reg[JOB_INNER]) begin
            job = JOB_INNER;
        end else if (w_mask_reg[JOB_RIGHT]) begin
            job = JOB_RIGHT;
        end else if (w_mask_reg[JOB_BELOW]) begin
            job = JOB_BELOW;
        end else begin
            job = JOB_CORNER;
        end
    end

    assign w_busy = (w_mask_reg != '0);
    assign w_last = ((w_mask_reg & (w_mask_reg - 1'b1)) == '0);

    // window stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_mask_reg <= '0;
        end else if (s1_ld_w) begin
            w_mask_reg <= s1_mask_reg;
        end else if (p_ld) begin
            w_mask_reg <= w_mask_reg & ~(4'b0001 << job);
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ld_w) begin
            w_row_reg <= s1_row_reg;
            w_col_reg <= s1_col_reg;
        end
    end

    // column cells, newest column on the right
    always_comb begin
        ctrl.shift  = s1_ld_w;
        ctrl.clear  = s1_clear_reg;
        ctrl.issue  = p_ld;
        ctrl.vshift = job[1];
        ctrl.hshift = job[0];
        ctrl.sum_en = q_ld;
        ctrl_right       = ctrl;
        ctrl_right.clear = 1'b0;
    end

    for (genvar k = 0; k < 3; k++) begin : g_cell
        assign coef_col[k][0] = coef_top_reg[k*COEF_W +: COEF_W];
        assign coef_col[k][1] = coef_mid_reg[k*COEF_W +: COEF_W];
        assign coef_col[k][2] = coef_bot_reg[k*COEF_W +: COEF_W];

        if (k == 2) begin : g_right
            c3zp_col_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl_right),
                .shift_in  (new_col),
                .right_col ('0),
                .coef_col  (coef_col[k]),
                .col_out   (cell_col[k]),
                .part_out  (part[k])
            );
        end else begin : g_inner
            c3zp_col_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .shift_in  (cell_col[k+1]),
                .right_col (cell_col[k+1]),
                .coef_col  (coef_col[k]),
                .col_out   (cell_col[k]),
                .part_out  (part[k])
            );
        end
    end

    // product stage tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (p_ld) begin
            p_valid_reg <= 1'b1;
        end else if (q_ld) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_ld) begin
            p_row_reg  <= job[1] ? w_row_reg : w_row_reg - 1'b1;
            p_col_reg  <= job[0] ? w_col_reg : w_col_reg - 1'b1;
            p_last_reg <= w_last;
            p_done_reg <= (job == JOB_CORNER);
        end
    end

    // column sum stage tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (q_ld) begin
            q_valid_reg <= 1'b1;
        end else if (o_ld) begin
            q_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ld) begin
            q_row_reg  <= p_row_reg;
            q_col_reg  <= p_col_reg;
            q_last_reg <= p_last_reg;
            q_done_reg <= p_done_reg;
        end
    end

    // output register, exact sum of the three column partials
    assign total = (PART_W+2)'(part[0]) + (PART_W+2)'(part[1]) + (PART_W+2)'(part[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (o_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_ld) begin
            filt_reg   <= total[SUM_W-1:0];
            o_row_reg  <= q_row_reg;
            o_col_reg  <= q_col_reg;
            o_last_reg <= q_last_reg;
            o_done_reg <= q_done_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_filtered   = filt_reg;
    assign m_out_row    = o_row_reg;
    assign m_out_col    = o_col_reg;
    assign m_run_last   = o_last_reg;
    assign m_frame_done = o_done_reg;

endmodule

// File: hw/rtl/c3zp_checker.sv
module c3zp_checker
    import c3zp_pkg::*;
#(
    parameter  int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int COL_W     = $clog2(MAX_WIDTH)
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [SUM_W-1:0] m_filtered,
    input logic [ROW_W-1:0]        m_out_row,
    input logic [COL_W-1:0]        m_out_col,
    input logic                    m_run_last,
    input logic                    m_frame_done,
    input logic                    psel,
    input logic                    pready
);

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_filtered) && $stable(m_out_row)
            && $stable(m_out_col) && $stable(m_run_last) && $stable(m_frame_done))
        else $error("result beat changed while stalled");

    // the corner result closes the run of its pixel
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_run_last)
        else $error("frame done without run last");

    // no result beat straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat shown after reset");

    // register port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        psel |-> pready)
        else $error("register port stalled");

endmodule

bind conv3x3_zero_padded_stream_core c3zp_checker #(
    .MAX_WIDTH (MAX_WIDTH)
) u_c3zp_checker (.*);

// File: tb/tb_conv3x3_zero_padded_stream_core.sv
module tb_conv3x3_zero_padded_stream_core;
    import c3zp_pkg::*;

    localparam int COL_W         = $clog2(DEF_MAX_WIDTH);
    localparam int MAX_HEIGHT    = 4096;
    localparam int REG_STRIDE    = 8;
    localparam int DRAIN_CYCLES  = 12;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_PIXELS = 320;

    // register indexes
    localparam int unsigned REG_COEFF_TOP = 0;
    localparam int unsigned REG_COEFF_MID = 1;
    localparam int unsigned REG_COEFF_BOT = 2;
    localparam int unsigned REG_ROWS      = 3;
    localparam int unsigned REG_COLS      = 4;
    localparam int unsigned REG_SPARE     = 5;

    typedef enum {STEP_WRITE, STEP_PIXEL} step_kind_e;

    typedef struct packed {
        logic signed [SUM_W-1:0] filtered;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic                    last;
        logic                    done;
    } result_t;

    typedef struct {
        step_kind_e      kind;
        int unsigned     idx;
        logic [63:0]     value;
        bit              typed;
        longint          sum;
    } step_t;

    logic                    aclk    = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    pix_t                    s_pixel = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [SUM_W-1:0] m_filtered;
    logic [ROW_W-1:0]        m_out_row;
    logic [COL_W-1:0]        m_out_col;
    logic                    m_run_last;
    logic                    m_frame_done;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [5:0]              paddr   = '0;
    logic [63:0]             pwdata  = '0;
    logic [63:0]             prdata;
    logic                    pready;

    // kernel and geometry as the block should hold them
    logic [47:0]  k_top    = 48'h0;
    logic [47:0]  k_mid    = 48'h0000_1000_0000;
    logic [47:0]  k_bot    = 48'h0;
    logic [12:0]  rows_reg = 13'd1024;
    logic [11:0]  cols_reg = 12'd1024;

    // line stores, 3x3 window ([column][row], column 2 newest) and frame position
    pix_t         line_older [DEF_MAX_WIDTH];
    pix_t         line_newer [DEF_MAX_WIDTH];
    longint       win [3][3];
    int unsigned  row_pos;
    int unsigned  col_pos;

    result_t      fresh_results[$];
    result_t      pending_results[$];
    step_t        directed_steps[$];

    int unsigned  idle_pct  = 7;
    int unsigned  stall_pct = 7;
    int unsigned  error_count;
    int unsigned  pixels_sent;
    int unsigned  results_checked;
    int unsigned  writes_done;
    int unsigned  quiet_cycles;

    conv3x3_zero_padded_stream_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_filtered   (m_filtered),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_run_last   (m_run_last),
        .m_frame_done (m_frame_done),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 12 unit clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // effective image size, zero acts as one, large values saturate
    function automatic int unsigned frame_height();
        if (rows_reg == 0) return 1;
        return (rows_reg > MAX_HEIGHT) ? MAX_HEIGHT : rows_reg;
    endfunction

    function automatic int unsigned frame_width();
        if (cols_reg == 0) return 1;
        return (cols_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cols_reg;
    endfunction

    function automatic void restart_frame();
        row_pos = 0;
        col_pos = 0;
        foreach (win[i, j]) win[i][j] = 0;
    endfunction

    function automatic int kernel_tap(int ky, int kx);
        logic [47:0] slots;
        slots = (ky == 0) ? k_top : ((ky == 1) ? k_mid : k_bot);
        return $signed(slots[kx*COEF_W +: COEF_W]);
    endfunction

    // vshift drops the top window row, hshift drops the left window column; the bottom and right taps then see zero
    function automatic longint window_sum(int vshift, int hshift);
        longint acc;
        acc = 0;
        for (int ky = 0; ky < 3; ky++)
            for (int kx = 0; kx < 3; kx++)
                if (ky + vshift < 3 && kx + hshift < 3)
                    acc += win[kx+hshift][ky+vshift] * kernel_tap(ky, kx);
        return acc;
    endfunction

    function automatic void queue_result(longint acc, int unsigned r, int unsigned c, bit done);
        result_t res;
        res.filtered = acc[SUM_W-1:0];
        res.row      = r[ROW_W-1:0];
        res.col      = c[COL_W-1:0];
        res.last     = 1'b0;
        res.done     = done;
        fresh_results.push_back(res);
    endfunction

    // results caused by one accepted pixel, in raster order of their centres
    function automatic void filter_pixel(pix_t pixel);
        int unsigned h, w, r, c;
        longint above, middle;
        result_t tail;
        h = frame_height();
        w = frame_width();
        fresh_results.delete();
        if (row_pos >= h || col_pos >= w) restart_frame();
        r = row_pos;
        c = col_pos;
        above  = (r >= 2) ? longint'(line_older[c]) : 0;
        middle = (r >= 1) ? longint'(line_newer[c]) : 0;
        line_older[c] = line_newer[c];
        line_newer[c] = pixel;
        if (c == 0) foreach (win[i, j]) win[i][j] = 0;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = win[i+1][j];
        win[2][0] = above;
        win[2][1] = middle;
        win[2][2] = pixel;
        if (r >= 1 && c >= 1)         queue_result(window_sum(0, 0), r - 1, c - 1, 1'b0);
        if (r >= 1 && c == w - 1)     queue_result(window_sum(0, 1), r - 1, w - 1, 1'b0);
        if (r == h - 1 && c >= 1)     queue_result(window_sum(1, 0), r, c - 1, 1'b0);
        if (r == h - 1 && c == w - 1) queue_result(window_sum(1, 1), r, w - 1, 1'b1);
        if (fresh_results.size() > 0) begin
            tail = fresh_results[fresh_results.size()-1];
            tail.last = 1'b1;
            fresh_results[fresh_results.size()-1] = tail;
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endfunction

    function automatic void add_step(step_kind_e kind, int unsigned idx, logic [63:0] value,
                                     bit typed, longint sum);
        step_t s;
        s.kind  = kind;
        s.idx   = idx;
        s.value = value;
        s.typed = typed;
        s.sum   = sum;
        directed_steps.push_back(s);
    endfunction

    function automatic logic [63:0] pick_coeffs(int unsigned sel);
        case (sel)
            0:       return 64'h0000_8000_8000_8000;
            1:       return 64'h0000_7FFF_7FFF_7FFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic pix_t random_pixel();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return pix_t'($urandom);
        endcase
    endfunction

    // stop feeding and let every expected beat drain, plus pipeline slack
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(int unsigned idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx * REG_STRIDE);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(int unsigned idx, output logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 6'(idx * REG_STRIDE);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        value   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // write a register while idle, mirror it and read it back if it is one of the five in use
    task automatic configure(int unsigned idx, logic [63:0] value);
        logic [63:0] stored, seen;
        wait_idle();
        apb_write(idx, value);
        writes_done++;
        stored = '0;
        case (idx)
            REG_COEFF_TOP: begin
                stored = {16'h0, value[47:0]};
                k_top  = value[47:0];
            end
            REG_COEFF_MID: begin
                stored = {16'h0, value[47:0]};
                k_mid  = value[47:0];
            end
            REG_COEFF_BOT: begin
                stored = {16'h0, value[47:0]};
                k_bot  = value[47:0];
            end
            REG_ROWS: begin
                stored   = {51'h0, value[12:0]};
                rows_reg = value[12:0];
                restart_frame();
            end
            REG_COLS: begin
                stored   = {52'h0, value[11:0]};
                cols_reg = value[11:0];
                restart_frame();
            end
            default: ;
        endcase
        if (idx <= REG_COLS) begin
            apb_read(idx, seen);
            if (seen !== stored) begin
                $error("register %0d: expected %0h, got %0h", idx, stored, seen);
                error_count++;
            end
        end
    endtask

    // one pixel beat; a typed sum replaces the predicted single result of a 1x1 frame
    task automatic send_pixel(pix_t value, bit typed, longint typed_sum);
        result_t want;
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid <= 1'b1;
        s_pixel <= value;
        do @(posedge aclk); while (!s_ready);
        filter_pixel(value);
        pixels_sent++;
        if (typed) begin
            want = '{filtered: typed_sum[SUM_W-1:0], row: '0, col: '0, last: 1'b1, done: 1'b1};
            pending_results.push_back(want);
        end else begin
            foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
        end
    endtask

    // result side: random back-pressure and in-order checking
    always @(posedge aclk) begin : result_sink
        result_t want;
        m_ready <= ($urandom_range(99) >= stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: row %0d col %0d",
                       m_out_row, m_out_col);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_filtered !== want.filtered) begin
                    $error("filtered: expected %0d, got %0d", $signed(want.filtered),
                           m_filtered);
                    error_count++;
                end
                if (m_out_row !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, m_out_row);
                    error_count++;
                end
                if (m_out_col !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col, m_out_col);
                    error_count++;
                end
                if (m_run_last !== want.last) begin
                    $error("run_last: expected %0d, got %0d", want.last, m_run_last);
                    error_count++;
                end
                if (m_frame_done !== want.done) begin
                    $error("frame_done: expected %0d, got %0d", want.done, m_frame_done);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat and no register access
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned random_sent, mode, phase_len, h_val, w_val;
        random_sent = 0;
        restart_frame();

        // 1x1 frames give the centre tap alone
        add_step(STEP_WRITE, REG_ROWS, 64'd1, 1'b0, 0);
        add_step(STEP_WRITE, REG_COLS, 64'd1, 1'b0, 0);
        add_step(STEP_PIXEL, 0, 64'h7FFF, 1'b1, 134213632);
        add_step(STEP_PIXEL, 0, 64'h8000, 1'b1, -134217728);
        add_step(STEP_PIXEL, 0, 64'h0000, 1'b1, 0);
        add_step(STEP_WRITE, REG_COEFF_MID, 64'h0000_0000_8000_0000, 1'b0, 0);
        add_step(STEP_PIXEL, 0, 64'h8000, 1'b1, 1073741824);
        add_step(STEP_PIXEL, 0, 64'h7FFF, 1'b1, -1073709056);
        // full-scale kernels on a 3x3 frame of most negative pixels
        add_step(STEP_WRITE, REG_COEFF_TOP, 64'h0000_8000_8000_8000, 1'b0, 0);
        add_step(STEP_WRITE, REG_COEFF_MID, 64'h0000_8000_8000_8000, 1'b0, 0);
        add_step(STEP_WRITE, REG_COEFF_BOT, 64'h0000_8000_8000_8000, 1'b0, 0);
        add_step(STEP_WRITE, REG_ROWS, 64'd3, 1'b0, 0);
        add_step(STEP_WRITE, REG_COLS, 64'd3, 1'b0, 0);
        repeat (9) add_step(STEP_PIXEL, 0, 64'h8000, 1'b0, 0);
        add_step(STEP_WRITE, REG_COEFF_TOP, 64'h0000_7FFF_7FFF_7FFF, 1'b0, 0);
        add_step(STEP_WRITE, REG_COEFF_MID, 64'h0000_7FFF_7FFF_7FFF, 1'b0, 0);
        add_step(STEP_WRITE, REG_COEFF_BOT, 64'h0000_7FFF_7FFF_7FFF, 1'b0, 0);
        repeat (9) add_step(STEP_PIXEL, 0, 64'h8000, 1'b0, 0);
        // zero sizes act as one
        add_step(STEP_WRITE, REG_ROWS, 64'd0, 1'b0, 0);
        add_step(STEP_WRITE, REG_COLS, 64'd0, 1'b0, 0);
        add_step(STEP_PIXEL, 0, 64'h0100, 1'b0, 0);
        // write to an unused address must not disturb anything
        add_step(STEP_WRITE, REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0);
        add_step(STEP_PIXEL, 0, 64'h5A5A, 1'b0, 0);
        // oversize geometry saturates
        add_step(STEP_WRITE, REG_ROWS, 64'd8191, 1'b0, 0);
        add_step(STEP_WRITE, REG_COLS, 64'd4095, 1'b0, 0);
        add_step(STEP_PIXEL, 0, 64'h1234, 1'b0, 0);
        add_step(STEP_PIXEL, 0, 64'hEDCB, 1'b0, 0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_WRITE)
                configure(directed_steps[i].idx, directed_steps[i].value);
            else
                send_pixel(directed_steps[i].value[PIX_W-1:0], directed_steps[i].typed,
                           directed_steps[i].sum);
        end

        // random phases of geometry and kernel
        while (random_sent < RANDOM_PIXELS) begin
            mode = $urandom_range(9);
            if (mode == 0) begin
                // widest lines, only a short run into the frame
                configure(REG_COLS, $urandom_range(1) ? 64'd2048 : 64'd4095);
                configure(REG_ROWS, $urandom_range(1) ? 64'd1 : 64'd8191);
                phase_len = 40;
            end else if (mode < 8) begin
                h_val = $urandom_range(1, 6);
                w_val = $urandom_range(1, 8);
                if (mode == 1) begin
                    if ($urandom_range(1)) h_val = 0;
                    else w_val = 0;
                end
                configure(REG_ROWS, 64'(h_val));
                configure(REG_COLS, 64'(w_val));
                phase_len = frame_height() * frame_width() * $urandom_range(1, 3)
                          + $urandom_range(0, frame_width());
            end else begin
                // kernel change only, the frame carries on
                phase_len = $urandom_range(4, 30);
            end
            for (int k = 0; k < 3; k++)
                if ($urandom_range(2) != 0)
                    configure(REG_COEFF_TOP + k, pick_coeffs($urandom_range(5)));
            if ($urandom_range(7) == 0) configure(REG_SPARE, {$urandom, $urandom});
            for (int unsigned n = 0; n < phase_len && random_sent < RANDOM_PIXELS; n++) begin
                // a long stretch with neither side idling
                idle_pct  = (random_sent >= 120 && random_sent < 230) ? 0 : 7;
                stall_pct = idle_pct;
                send_pixel(random_pixel(), 1'b0, 0);
                random_sent++;
            end
        end

        wait_idle();
        $display("%0d pixel beats gave %0d checked result beats across %0d register writes",
                 pixels_sent, results_checked, writes_done);
        $display("frames from 1x1 up to saturated geometry, with extreme and random kernels");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
